>>> design/ssms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared types and constants of the symmetric sparse matrix store.
// ----------------------------------------------------------------------------
package ssms_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int CAPACITY_DEF = 256;

    localparam logic [1:0] FUNC_SET = 2'd0;
    localparam logic [1:0] FUNC_GET = 2'd1;
    localparam logic [1:0] FUNC_DEL = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOB  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [1:0] REG_MATRIX_SIDE = 2'd0;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
    } t_result;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INC,
        CELL_DEC,
        CELL_SCAN,
        CELL_FINISH,
        CELL_SHIFT
    } t_cell_op;

endpackage

>>> design/symmetric_sparse_matrix_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_sparse_matrix_store_top
// Upper triangle of a symmetric sparse matrix in compressed-column form.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and the result shows
// on o_result with o_done high for one cycle; the receiver cannot stall it.
// A get or an overwrite searches the entries of the column; an insert or a
// removal also moves each later entry by one place; a delete passes over
// every entry in the store. Column pointers live in a row of cells that
// update in parallel. Out-of-range items answer in the cycle after start.
// No clearing pass.
// ----------------------------------------------------------------------------
module symmetric_sparse_matrix_store_top #(
    parameter int MAX_SIDE = ssms_pkg::MAX_SIDE_DEF,
    parameter int CAPACITY = ssms_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ssms_pkg::t_item   i_item,
    output logic              o_done,
    output ssms_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = IW + 32;

    typedef enum logic [3:0] {
        S_IDLE, S_RANGE, S_SRD, S_SCMP, S_DECIDE, S_DNRD, S_DNWR,
        S_UPRD, S_UPWR, S_DSTART, S_DRD, S_DPROC, S_DFIN, S_DSHIFT
    } t_state;

    t_state        r_state;
    logic [1:0]    r_func;
    logic [IW-1:0] r_r, r_c;
    logic [31:0]   r_value;
    logic [PW-1:0] r_p, r_hi, r_k, r_w, r_rem, r_dlo, r_dhi, r_count;
    logic [SW-1:0] r_live;
    logic          r_found;
    logic          r_done;
    logic [1:0]    r_status;
    logic [31:0]   r_rdval;

    logic [PW-1:0] w_ptr [MAX_SIDE];
    logic [PW-1:0] w_cs_c, w_cs_c1, w_lo, w_hi;
    logic [DW-1:0] w_rdata, w_wdata;
    logic [IW-1:0] w_rd_row;
    logic [31:0]   w_rd_val;
    logic          w_we, w_re, w_cfg_wr, w_zero, w_removed;
    logic [AW-1:0] w_waddr, w_raddr;
    ssms_pkg::t_cell_op w_op;
    logic [6:0]    w_side_in;
    logic [SW-1:0] w_side;

    assign pready    = 1'b1;
    assign prdata    = 32'(r_live);
    assign w_cfg_wr  = psel && penable && pwrite && paddr == ssms_pkg::REG_MATRIX_SIDE;
    assign w_side_in = pwdata[6:0];
    assign w_side    = (w_side_in == 7'd0) ? SW'(1) :
                       (32'(w_side_in) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(w_side_in);

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = '{status: r_status, read_value: r_rdval};

    assign w_rd_row  = w_rdata[DW-1:32];
    assign w_rd_val  = w_rdata[31:0];
    assign w_zero    = r_value[30:0] == 31'd0;
    assign w_removed = (r_k >= r_dlo && r_k < r_dhi) || w_rd_row == r_c;

    assign w_cs_c  = w_ptr[r_c];
    assign w_cs_c1 = (SW'(r_c) + SW'(1) < r_live) ? w_ptr[r_c + IW'(1)] : r_count;
    assign w_hi    = (w_cs_c1 > r_count) ? r_count : w_cs_c1;
    assign w_lo    = (w_cs_c > w_hi) ? w_hi : w_cs_c;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_p[AW-1:0];
        w_raddr = r_p[AW-1:0];
        w_wdata = {r_r, r_value};
        w_op    = w_cfg_wr ? ssms_pkg::CELL_CLEAR : ssms_pkg::CELL_HOLD;
        unique case (r_state)
            S_SRD: w_re = r_p < r_hi;
            S_DECIDE: w_we = r_func == ssms_pkg::FUNC_SET && r_found && !w_zero;
            S_DNRD: begin
                w_raddr = AW'(r_k + PW'(1));
                if (r_k + PW'(1) < r_count) w_re = 1'b1;
                else w_op = ssms_pkg::CELL_DEC;
            end
            S_DNWR, S_UPWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                w_wdata = w_rdata;
            end
            S_UPRD: begin
                w_raddr = AW'(r_k - PW'(1));
                if (r_k > r_p) begin
                    w_re = 1'b1;
                end else begin
                    w_we = 1'b1;
                    w_op = ssms_pkg::CELL_INC;
                end
            end
            S_DRD: begin
                w_raddr = r_k[AW-1:0];
                w_re    = r_k < r_count;
            end
            S_DPROC: begin
                w_op    = ssms_pkg::CELL_SCAN;
                w_we    = !w_removed;
                w_waddr = r_w[AW-1:0];
                w_wdata = {(w_rd_row > r_c) ? w_rd_row - IW'(1) : w_rd_row, w_rd_val};
            end
            S_DFIN:   w_op = ssms_pkg::CELL_FINISH;
            S_DSHIFT: w_op = ssms_pkg::CELL_SHIFT;
            default: begin
            end
        endcase
    end

    ssms_mem #(.AW(AW), .DW(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    for (genvar j = 0; j < MAX_SIDE; j++) begin : g_cell
        logic [PW-1:0] w_next;
        if (j == MAX_SIDE - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_ptr[j+1];
        end
        ssms_cell #(.J(j), .IW(IW), .SW(SW), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_col   (r_c),
            .i_live  (r_live),
            .i_k     (r_k),
            .i_rem   (r_rem),
            .i_next  (w_next),
            .o_ptr   (w_ptr[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= SW'(MAX_SIDE > 64 ? 64 : MAX_SIDE);
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ssms_pkg::STATUS_OK;
            r_rdval  <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_cfg_wr) begin
                r_live  <= w_side;
                r_count <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_item.func;
                        r_value  <= i_item.value;
                        r_rdval  <= '0;
                        r_status <= ssms_pkg::STATUS_OK;
                        if (i_item.func == ssms_pkg::FUNC_DEL || i_item.row < i_item.col) begin
                            r_r <= IW'(i_item.row);
                            r_c <= IW'(i_item.col);
                        end else begin
                            r_r <= IW'(i_item.col);
                            r_c <= IW'(i_item.row);
                        end
                        case (i_item.func)
                            ssms_pkg::FUNC_SET, ssms_pkg::FUNC_GET: begin
                                if (32'(i_item.row) >= 32'(r_live) ||
                                    32'(i_item.col) >= 32'(r_live)) begin
                                    r_status <= ssms_pkg::STATUS_OOB;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_RANGE;
                                end
                            end
                            ssms_pkg::FUNC_DEL: begin
                                if (32'(i_item.col) >= 32'(r_live)) begin
                                    r_status <= ssms_pkg::STATUS_OOB;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_DSTART;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_RANGE: begin
                    r_p     <= w_lo;
                    r_hi    <= w_hi;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    if (r_p < r_hi) begin
                        r_state <= S_SCMP;
                    end else begin
                        r_found <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                S_SCMP: begin
                    if (w_rd_row < r_r) begin
                        r_p     <= r_p + PW'(1);
                        r_state <= S_SRD;
                    end else begin
                        r_found <= w_rd_row == r_r;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_func == ssms_pkg::FUNC_GET) begin
                        r_rdval <= r_found ? w_rd_val : 32'd0;
                    end else if (r_found && w_zero) begin
                        r_k     <= r_p;
                        r_done  <= 1'b0;
                        r_state <= S_DNRD;
                    end else if (!r_found && !w_zero) begin
                        if (32'(r_count) >= 32'(CAPACITY)) begin
                            r_status <= ssms_pkg::STATUS_FULL;
                        end else begin
                            r_k     <= r_count;
                            r_done  <= 1'b0;
                            r_state <= S_UPRD;
                        end
                    end
                end
                S_DNRD: begin
                    if (r_k + PW'(1) < r_count) begin
                        r_state <= S_DNWR;
                    end else begin
                        r_count <= r_count - PW'(1);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DNWR: begin
                    r_k     <= r_k + PW'(1);
                    r_state <= S_DNRD;
                end
                S_UPRD: begin
                    if (r_k > r_p) begin
                        r_state <= S_UPWR;
                    end else begin
                        r_count <= r_count + PW'(1);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_UPWR: begin
                    r_k     <= r_k - PW'(1);
                    r_state <= S_UPRD;
                end
                S_DSTART: begin
                    r_dlo   <= w_lo;
                    r_dhi   <= w_hi;
                    r_k     <= '0;
                    r_w     <= '0;
                    r_rem   <= '0;
                    r_state <= S_DRD;
                end
                S_DRD: r_state <= (r_k < r_count) ? S_DPROC : S_DFIN;
                S_DPROC: begin
                    if (w_removed) r_rem <= r_rem + PW'(1);
                    else r_w <= r_w + PW'(1);
                    r_k     <= r_k + PW'(1);
                    r_state <= S_DRD;
                end
                S_DFIN: r_state <= S_DSHIFT;
                S_DSHIFT: begin
                    r_count <= r_w;
                    r_live  <= r_live - SW'(1);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/ssms_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssms_mem #(
    parameter int AW = 8,
    parameter int DW = 38
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ssms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_cell
// One column start pointer. Adjusts itself on insert, remove and delete and
// takes its upper neighbor's pointer when a column at or below it is deleted.
// ----------------------------------------------------------------------------
module ssms_cell #(
    parameter int J  = 0,
    parameter int IW = 6,
    parameter int SW = 7,
    parameter int PW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssms_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_col,
    input  logic [SW-1:0]     i_live,
    input  logic [PW-1:0]     i_k,
    input  logic [PW-1:0]     i_rem,
    input  logic [PW-1:0]     i_next,
    output logic [PW-1:0]     o_ptr
);

    logic [PW-1:0] r_ptr;
    logic          r_latched;
    logic          w_above;
    logic          w_in_live;

    assign w_above   = 32'(J) > 32'(i_col);
    assign w_in_live = 32'(J) < 32'(i_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_latched <= 1'b0;
        end else begin
            case (i_op)
                ssms_pkg::CELL_CLEAR: begin
                    r_ptr     <= '0;
                    r_latched <= 1'b0;
                end
                ssms_pkg::CELL_INC: begin
                    if (w_above && w_in_live) r_ptr <= r_ptr + PW'(1);
                end
                ssms_pkg::CELL_DEC: begin
                    if (w_above && w_in_live && r_ptr != '0) r_ptr <= r_ptr - PW'(1);
                end
                ssms_pkg::CELL_SCAN: begin
                    if (!r_latched && i_k == r_ptr) begin
                        r_ptr     <= r_ptr - i_rem;
                        r_latched <= 1'b1;
                    end
                end
                ssms_pkg::CELL_FINISH: begin
                    if (!r_latched) r_ptr <= r_ptr - i_rem;
                    r_latched <= 1'b0;
                end
                ssms_pkg::CELL_SHIFT: begin
                    if (32'(J) + 1 >= 32'(i_live)) begin
                        r_ptr <= '0;
                    end else if (32'(J) >= 32'(i_col)) begin
                        r_ptr <= i_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ptr = r_ptr;

endmodule
